// ----- src/pinhole_ray_direction_core_assert.svh -----
// pinhole_ray_direction_core_assert.svh
// Assertion macros for the pinhole ray direction core; no dependencies.
`ifndef PINHOLE_RAY_DIRECTION_CORE_ASSERT_SVH
`define PINHOLE_RAY_DIRECTION_CORE_ASSERT_SVH
// Same-cycle implication.
`define RPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpd: assertion failed");
// Implication after a fixed number of cycles.
`define RPD_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("rpd: assertion failed");
`endif

// ----- src/rpd_pkg.sv -----
// rpd_pkg.sv
// Shared constants, types and width helpers for the pinhole ray direction core.
// No dependencies.
package rpd_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COMP_BITS_DEF  = 20;
    localparam int PITCH_BITS     = 24;
    localparam int NORM_BITS      = 30;
    localparam int SUM_BITS       = 2 * NORM_BITS + 2;
    localparam int ROOT_BITS      = NORM_BITS + 1;
    localparam int FRAC_BITS      = 16;
    localparam int Q_BITS         = FRAC_BITS + 1;
    localparam int OUT_BITS       = Q_BITS + 1;
    localparam int CFG_IDX_BITS   = 3;

    localparam logic [Q_BITS-1:0] UNIT_Q = Q_BITS'(65536);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_VEC = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_VEC = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UP_VEC    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PIX_W     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PIX_H     = 3'd4;

    // Pipeline depth of each unit.
    localparam int MAC_STAGES  = 4;
    localparam int NORM_STAGES = 5;
    localparam int SQRT_STAGES = ROOT_BITS;
    localparam int DIV_STAGES  = Q_BITS + 1;
    localparam int OUT_STAGES  = 1;
    localparam int LATENCY     = MAC_STAGES + NORM_STAGES + SQRT_STAGES + DIV_STAGES
                                 + OUT_STAGES;

    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } t_flags;

    typedef struct packed {
        logic   valid;
        t_flags flags;
    } t_ctl;

    // Width of the exact unnormalized direction components, sign included.
    function automatic int mag_width(input int coord_bits, input int comp_bits);
        return coord_bits + PITCH_BITS + comp_bits + 3;
    endfunction

endpackage

// ----- src/rpd_mac.sv -----
// rpd_mac.sv
// Exact direction vector: pitch scaling, axis products, sum, sign/magnitude split.
// Depends on rpd_pkg.
module rpd_mac #(
    parameter int COORD_BITS = rpd_pkg::COORD_BITS_DEF,
    parameter int COMP_BITS  = rpd_pkg::COMP_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_vld,
    input  logic [COORD_BITS-1:0]                  i_pixel_x,
    input  logic [COORD_BITS-1:0]                  i_pixel_y,
    input  logic [3*COMP_BITS-1:0]                 i_start_vec,
    input  logic [3*COMP_BITS-1:0]                 i_right_vec,
    input  logic [3*COMP_BITS-1:0]                 i_up_vec,
    input  logic [rpd_pkg::PITCH_BITS-1:0]         i_pix_w,
    input  logic [rpd_pkg::PITCH_BITS-1:0]         i_pix_h,
    output logic                                   o_vld,
    output logic [2:0]                             o_neg,
    output logic [2:0][rpd_pkg::mag_width(COORD_BITS, COMP_BITS)-1:0] o_mag
);

    localparam int SX_W = COORD_BITS + rpd_pkg::PITCH_BITS;
    localparam int P_W  = SX_W + 1 + COMP_BITS;
    localparam int V_W  = rpd_pkg::mag_width(COORD_BITS, COMP_BITS);

    logic signed [COMP_BITS-1:0] start_c [3];
    logic signed [COMP_BITS-1:0] right_c [3];
    logic signed [COMP_BITS-1:0] up_c    [3];

    logic [3:0]             r_vld;
    logic [SX_W-1:0]        r_sx;
    logic [SX_W-1:0]        r_sy;
    logic signed [P_W-1:0]  r_pr [3];
    logic signed [P_W-1:0]  r_pu [3];
    logic signed [V_W-1:0]  r_v  [3];
    logic [2:0]             r_neg;
    logic [2:0][V_W-1:0]    r_mag;

    logic [SX_W-1:0]        n_sx;
    logic [SX_W-1:0]        n_sy;

    for (genvar k = 0; k < 3; k++) begin : g_comp
        assign start_c[k] = i_start_vec[k*COMP_BITS +: COMP_BITS];
        assign right_c[k] = i_right_vec[k*COMP_BITS +: COMP_BITS];
        assign up_c[k]    = i_up_vec[k*COMP_BITS +: COMP_BITS];
    end

    assign n_sx = SX_W'(i_pixel_x) * SX_W'(i_pix_w);
    assign n_sy = SX_W'(i_pixel_y) * SX_W'(i_pix_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx <= n_sx;
        r_sy <= n_sy;
        for (int k = 0; k < 3; k++) begin
            r_pr[k] <= $signed({1'b0, r_sx}) * right_c[k];
            r_pu[k] <= $signed({1'b0, r_sy}) * up_c[k];
            r_v[k]  <= (V_W'(start_c[k]) <<< rpd_pkg::PITCH_BITS) + V_W'(r_pr[k])
                       + V_W'(r_pu[k]);
            r_neg[k] <= r_v[k][V_W-1];
            r_mag[k] <= r_v[k][V_W-1] ? V_W'(-r_v[k]) : V_W'(r_v[k]);
        end
    end

    assign o_vld = r_vld[3];
    assign o_neg = r_neg;
    assign o_mag = r_mag;

endmodule

// ----- src/rpd_norm.sv -----
// rpd_norm.sv
// Common normalizing shift to 30 bits, squares and their sum.
// Depends on rpd_pkg.
module rpd_norm #(
    parameter int MAG_W = rpd_pkg::mag_width(rpd_pkg::COORD_BITS_DEF, rpd_pkg::COMP_BITS_DEF)
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_vld,
    input  logic [2:0]                                  i_neg,
    input  logic [2:0][MAG_W-1:0]                       i_mag,
    output rpd_pkg::t_ctl                               o_ctl,
    output logic [2:0][rpd_pkg::NORM_BITS-1:0]          o_mag,
    output logic [rpd_pkg::SUM_BITS-1:0]                o_sum
);

    localparam int NG    = (MAG_W + 7) / 8;
    localparam int PAD_W = NG * 8;
    localparam int BL_W  = $clog2(MAG_W + 1);
    localparam int NB    = rpd_pkg::NORM_BITS;
    localparam int SQ_W  = 2 * NB;

    logic [4:0]               r_vld;
    logic [2:0]               r1_neg, r2_neg, r3_neg, r4_neg, r5_neg;
    logic                     r2_zero, r3_zero, r4_zero, r5_zero;
    logic [2:0][MAG_W-1:0]    r1_mag, r2_mag;
    logic [3:0]               r1_lb [NG];
    logic                     r2_rsh;
    logic [BL_W-1:0]          r2_amt;
    logic [2:0][NB-1:0]       r3_mag, r4_mag, r5_mag;
    logic [SQ_W-1:0]          r4_sq [3];
    logic [rpd_pkg::SUM_BITS-1:0] r5_sum;

    logic [PAD_W-1:0]         n_or;
    logic [3:0]               n_lb [NG];
    logic [BL_W-1:0]          n_bl;
    logic [2:0][NB-1:0]       n_shift;
    logic [MAG_W-1:0]         sh_tmp;

    // Bit length of the OR equals bit length of the largest magnitude.
    always_comb begin
        n_or = PAD_W'(i_mag[0] | i_mag[1] | i_mag[2]);
        for (int g = 0; g < NG; g++) begin
            n_lb[g] = '0;
            for (int i = 0; i < 8; i++) begin
                if (n_or[g*8 + i]) begin
                    n_lb[g] = 4'(i + 1);
                end
            end
        end
    end

    always_comb begin
        n_bl = '0;
        for (int g = 0; g < NG; g++) begin
            if (r1_lb[g] != '0) begin
                n_bl = BL_W'(g * 8) + BL_W'(r1_lb[g]);
            end
        end
    end

    always_comb begin
        sh_tmp = '0;
        for (int k = 0; k < 3; k++) begin
            sh_tmp     = r2_rsh ? (r2_mag[k] >> r2_amt) : (r2_mag[k] << r2_amt);
            n_shift[k] = sh_tmp[NB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        // find leading group
        r1_neg <= i_neg;
        r1_mag <= i_mag;
        r1_lb  <= n_lb;
        // choose shift direction and amount
        r2_neg  <= r1_neg;
        r2_mag  <= r1_mag;
        r2_zero <= (n_bl == '0);
        r2_rsh  <= (n_bl > BL_W'(NB));
        r2_amt  <= (n_bl > BL_W'(NB)) ? (n_bl - BL_W'(NB)) : (BL_W'(NB) - n_bl);
        // shift
        r3_neg  <= r2_neg;
        r3_zero <= r2_zero;
        r3_mag  <= n_shift;
        // square
        r4_neg  <= r3_neg;
        r4_zero <= r3_zero;
        r4_mag  <= r3_mag;
        for (int k = 0; k < 3; k++) begin
            r4_sq[k] <= SQ_W'(r3_mag[k]) * SQ_W'(r3_mag[k]);
        end
        // sum
        r5_neg  <= r4_neg;
        r5_zero <= r4_zero;
        r5_mag  <= r4_mag;
        r5_sum  <= rpd_pkg::SUM_BITS'(r4_sq[0]) + rpd_pkg::SUM_BITS'(r4_sq[1])
                   + rpd_pkg::SUM_BITS'(r4_sq[2]);
    end

    assign o_ctl.valid      = r_vld[4];
    assign o_ctl.flags.zero = r5_zero;
    assign o_ctl.flags.neg  = r5_neg;
    assign o_mag            = r5_mag;
    assign o_sum            = r5_sum;

endmodule

// ----- src/rpd_sqrt.sv -----
// rpd_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on rpd_pkg.
module rpd_sqrt (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rpd_pkg::t_ctl                        i_ctl,
    input  logic [2:0][rpd_pkg::NORM_BITS-1:0]   i_mag,
    input  logic [rpd_pkg::SUM_BITS-1:0]         i_sum,
    output rpd_pkg::t_ctl                        o_ctl,
    output logic [2:0][rpd_pkg::NORM_BITS-1:0]   o_mag,
    output logic [rpd_pkg::ROOT_BITS-1:0]        o_root
);

    localparam int S     = rpd_pkg::SQRT_STAGES;
    localparam int RB    = rpd_pkg::ROOT_BITS;
    localparam int SB    = rpd_pkg::SUM_BITS;
    localparam int REM_W = RB + 3;
    localparam int RS_W  = REM_W + 2;

    logic                              r_vld   [S];
    rpd_pkg::t_flags                   r_flags [S];
    logic [2:0][rpd_pkg::NORM_BITS-1:0] r_mag  [S];
    logic [REM_W-1:0]                  r_rem   [S];
    logic [RB-1:0]                     r_root  [S];
    logic [SB-1:0]                     r_n     [S];

    logic [REM_W-1:0]                  n_rem   [S];
    logic [RB-1:0]                     n_root  [S];
    logic [SB-1:0]                     n_n     [S];

    always_comb begin
        logic [REM_W-1:0] a_rem;
        logic [RB-1:0]    a_root;
        logic [SB-1:0]    a_n;
        logic [RS_W-1:0]  rs;
        logic [RS_W-1:0]  t;
        for (int s = 0; s < S; s++) begin
            if (s == 0) begin
                a_rem  = '0;
                a_root = '0;
                a_n    = i_sum;
            end else begin
                a_rem  = r_rem[s-1];
                a_root = r_root[s-1];
                a_n    = r_n[s-1];
            end
            // bring down the next pair of radicand bits
            rs = {a_rem, a_n[SB-1 -: 2]};
            t  = RS_W'({a_root, 2'b01});
            if (rs >= t) begin
                n_rem[s]  = REM_W'(rs - t);
                n_root[s] = {a_root[RB-2:0], 1'b1};
            end else begin
                n_rem[s]  = rs[REM_W-1:0];
                n_root[s] = {a_root[RB-2:0], 1'b0};
            end
            n_n[s] = {a_n[SB-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < S; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_ctl.valid;
            for (int s = 1; s < S; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags[0] <= i_ctl.flags;
        r_mag[0]   <= i_mag;
        for (int s = 1; s < S; s++) begin
            r_flags[s] <= r_flags[s-1];
            r_mag[s]   <= r_mag[s-1];
        end
        r_rem  <= n_rem;
        r_root <= n_root;
        r_n    <= n_n;
    end

    assign o_ctl.valid = r_vld[S-1];
    assign o_ctl.flags = r_flags[S-1];
    assign o_mag       = r_mag[S-1];
    assign o_root      = r_root[S-1];

endmodule

// ----- src/rpd_div.sv -----
// rpd_div.sv
// Pipelined rounded division of three magnitudes by the root, one quotient bit
// per stage. Depends on rpd_pkg.
module rpd_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rpd_pkg::t_ctl                        i_ctl,
    input  logic [2:0][rpd_pkg::NORM_BITS-1:0]   i_mag,
    input  logic [rpd_pkg::ROOT_BITS-1:0]        i_root,
    output rpd_pkg::t_ctl                        o_ctl,
    output logic [2:0][rpd_pkg::Q_BITS-1:0]      o_quo
);

    localparam int QB    = rpd_pkg::Q_BITS;
    localparam int RB    = rpd_pkg::ROOT_BITS;
    localparam int NB    = rpd_pkg::NORM_BITS;
    localparam int NUM_W = NB + rpd_pkg::FRAC_BITS + 1;

    // setup stage
    logic                  r0_vld;
    rpd_pkg::t_flags       r0_flags;
    logic [RB-1:0]         r0_root;
    logic [2:0][RB-1:0]    r0_rem;
    logic [2:0][QB-1:0]    r0_low;

    // quotient stages
    logic                  r_vld   [QB];
    rpd_pkg::t_flags       r_flags [QB];
    logic [RB-1:0]         r_root  [QB];
    logic [2:0][RB-1:0]    r_rem   [QB];
    logic [2:0][QB-1:0]    r_low   [QB];
    logic [2:0][QB-1:0]    r_q     [QB];

    logic [2:0][RB-1:0]    n0_rem;
    logic [2:0][QB-1:0]    n0_low;
    logic [2:0][RB-1:0]    n_rem   [QB];
    logic [2:0][QB-1:0]    n_low   [QB];
    logic [2:0][QB-1:0]    n_q     [QB];

    // Numerator is mag * 2^16 plus half the root; its top bits are already
    // below the root, so only the low bits need quotient steps.
    always_comb begin
        logic [NUM_W-1:0] num;
        for (int k = 0; k < 3; k++) begin
            num       = NUM_W'({i_mag[k], {rpd_pkg::FRAC_BITS{1'b0}}})
                        + NUM_W'(i_root[RB-1:1]);
            n0_rem[k] = RB'(num[NUM_W-1:QB]);
            n0_low[k] = num[QB-1:0];
        end
    end

    always_comb begin
        logic [RB-1:0] a_root;
        logic [RB-1:0] a_rem;
        logic [QB-1:0] a_low;
        logic [QB-1:0] a_q;
        logic [RB:0]   rs;
        for (int s = 0; s < QB; s++) begin
            for (int k = 0; k < 3; k++) begin
                if (s == 0) begin
                    a_root = r0_root;
                    a_rem  = r0_rem[k];
                    a_low  = r0_low[k];
                    a_q    = '0;
                end else begin
                    a_root = r_root[s-1];
                    a_rem  = r_rem[s-1][k];
                    a_low  = r_low[s-1][k];
                    a_q    = r_q[s-1][k];
                end
                rs = {a_rem, a_low[QB-1]};
                if (rs >= {1'b0, a_root}) begin
                    n_rem[s][k] = RB'(rs - {1'b0, a_root});
                    n_q[s][k]   = {a_q[QB-2:0], 1'b1};
                end else begin
                    n_rem[s][k] = rs[RB-1:0];
                    n_q[s][k]   = {a_q[QB-2:0], 1'b0};
                end
                n_low[s][k] = {a_low[QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            for (int s = 0; s < QB; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r0_vld   <= i_ctl.valid;
            r_vld[0] <= r0_vld;
            for (int s = 1; s < QB; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r0_flags   <= i_ctl.flags;
        r0_root    <= i_root;
        r0_rem     <= n0_rem;
        r0_low     <= n0_low;
        r_flags[0] <= r0_flags;
        r_root[0]  <= r0_root;
        for (int s = 1; s < QB; s++) begin
            r_flags[s] <= r_flags[s-1];
            r_root[s]  <= r_root[s-1];
        end
        r_rem <= n_rem;
        r_low <= n_low;
        r_q   <= n_q;
    end

    assign o_ctl.valid = r_vld[QB-1];
    assign o_ctl.flags = r_flags[QB-1];
    assign o_quo       = r_q[QB-1];

endmodule

// ----- src/pinhole_ray_direction_core.sv -----
// pinhole_ray_direction_core.sv
// Top level of the pinhole camera primary ray direction core.
// Depends on rpd_pkg, rpd_mac, rpd_norm, rpd_sqrt, rpd_div and the assertion header.
//
//  channel   handshake                 payload
//  --------  ------------------------  ---------------------------------------------
//  pixel in  start, busy               i_pixel_x, i_pixel_y
//  config    i_cfg_we                  i_cfg_idx, i_cfg_data
//  ray out   o_strobe (one cycle)      o_dir_x, o_dir_y, o_dir_z, o_zero_length
//
//  A pixel transaction is taken at every edge with start high and busy low; one
//  pixel per clock is sustained. Each result appears after its pixel has passed
//  4 vector stages, 5 normalize stages, 31 square-root stages (one root bit each),
//  18 divider stages (a setup stage, then one quotient bit each) and 1 output stage.
//  Synchronous active-low reset clears all valid bits and the configuration registers;
//  busy is high only during and right after reset. The receiver cannot stall, so the
//  pipeline never holds.

module pinhole_ray_direction_core #(
    parameter int COORD_BITS = rpd_pkg::COORD_BITS_DEF,
    parameter int COMP_BITS  = rpd_pkg::COMP_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [COORD_BITS-1:0]                i_pixel_x,
    input  logic [COORD_BITS-1:0]                i_pixel_y,
    input  logic                                 i_cfg_we,
    input  logic [rpd_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [3*COMP_BITS-1:0]               i_cfg_data,
    output logic                                 o_strobe,
    output logic signed [rpd_pkg::OUT_BITS-1:0]  o_dir_x,
    output logic signed [rpd_pkg::OUT_BITS-1:0]  o_dir_y,
    output logic signed [rpd_pkg::OUT_BITS-1:0]  o_dir_z,
    output logic                                 o_zero_length
);

    `include "pinhole_ray_direction_core_assert.svh"

    localparam int MAG_W   = rpd_pkg::mag_width(COORD_BITS, COMP_BITS);
    localparam int NB      = rpd_pkg::NORM_BITS;
    localparam int QB      = rpd_pkg::Q_BITS;
    localparam int OB      = rpd_pkg::OUT_BITS;
    localparam int PB      = rpd_pkg::PITCH_BITS;
    localparam int LATENCY = rpd_pkg::LATENCY;

    // configuration registers
    logic [3*COMP_BITS-1:0] r_start_vec;
    logic [3*COMP_BITS-1:0] r_right_vec;
    logic [3*COMP_BITS-1:0] r_up_vec;
    logic [PB-1:0]          r_pix_w;
    logic [PB-1:0]          r_pix_h;

    logic                   r_busy;
    logic                   r_strobe;
    logic                   r_zero;
    logic [OB-1:0]          r_dir [3];

    logic                   w_accept;
    logic                   w_mac_vld;
    logic [2:0]             w_mac_neg;
    logic [2:0][MAG_W-1:0]  w_mac_mag;
    rpd_pkg::t_ctl          w_norm_ctl;
    logic [2:0][NB-1:0]     w_norm_mag;
    logic [rpd_pkg::SUM_BITS-1:0] w_norm_sum;
    rpd_pkg::t_ctl          w_sqrt_ctl;
    logic [2:0][NB-1:0]     w_sqrt_mag;
    logic [rpd_pkg::ROOT_BITS-1:0] w_root;
    rpd_pkg::t_ctl          w_div_ctl;
    logic [2:0][QB-1:0]     w_quo;
    logic [OB-1:0]          n_dir [3];

    logic                   w_zero_ok;
    logic                   w_range_ok;

    assign w_accept = start && !busy;
    assign busy     = r_busy;

    // Hold busy through reset and the cycle after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Register file: indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_vec <= '0;
            r_right_vec <= '0;
            r_up_vec    <= '0;
            r_pix_w     <= '0;
            r_pix_h     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rpd_pkg::CFG_START_VEC: r_start_vec <= i_cfg_data;
                rpd_pkg::CFG_RIGHT_VEC: r_right_vec <= i_cfg_data;
                rpd_pkg::CFG_UP_VEC:    r_up_vec    <= i_cfg_data;
                rpd_pkg::CFG_PIX_W:     r_pix_w     <= i_cfg_data[PB-1:0];
                rpd_pkg::CFG_PIX_H:     r_pix_h     <= i_cfg_data[PB-1:0];
                default: begin
                end
            endcase
        end
    end

    // Exact direction vector, split into sign and magnitude.
    rpd_mac #(
        .COORD_BITS (COORD_BITS),
        .COMP_BITS  (COMP_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (w_accept),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_start_vec (r_start_vec),
        .i_right_vec (r_right_vec),
        .i_up_vec    (r_up_vec),
        .i_pix_w     (r_pix_w),
        .i_pix_h     (r_pix_h),
        .o_vld       (w_mac_vld),
        .o_neg       (w_mac_neg),
        .o_mag       (w_mac_mag)
    );

    // Scale all magnitudes so the largest has 30 bits; sum their squares.
    rpd_norm #(
        .MAG_W (MAG_W)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_mac_vld),
        .i_neg   (w_mac_neg),
        .i_mag   (w_mac_mag),
        .o_ctl   (w_norm_ctl),
        .o_mag   (w_norm_mag),
        .o_sum   (w_norm_sum)
    );

    // Vector length.
    rpd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_norm_ctl),
        .i_mag   (w_norm_mag),
        .i_sum   (w_norm_sum),
        .o_ctl   (w_sqrt_ctl),
        .o_mag   (w_sqrt_mag),
        .o_root  (w_root)
    );

    // Components over length, rounded to 16 fraction bits.
    rpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sqrt_ctl),
        .i_mag   (w_sqrt_mag),
        .i_root  (w_root),
        .o_ctl   (w_div_ctl),
        .o_quo   (w_quo)
    );

    // Clamp to one, apply the sign, and force zeros for a zero-length vector.
    always_comb begin
        logic [QB-1:0] q;
        logic [OB-1:0] m;
        for (int k = 0; k < 3; k++) begin
            q = (w_quo[k] > rpd_pkg::UNIT_Q) ? rpd_pkg::UNIT_Q : w_quo[k];
            m = {1'b0, q};
            if (w_div_ctl.flags.zero) begin
                n_dir[k] = '0;
            end else if (w_div_ctl.flags.neg[k]) begin
                n_dir[k] = -m;
            end else begin
                n_dir[k] = m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_div_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= w_div_ctl.flags.zero;
        r_dir  <= n_dir;
    end

    assign o_strobe      = r_strobe;
    assign o_zero_length = r_zero;
    assign o_dir_x       = r_dir[0];
    assign o_dir_y       = r_dir[1];
    assign o_dir_z       = r_dir[2];

    assign w_zero_ok  = (o_dir_x == '0) && (o_dir_y == '0) && (o_dir_z == '0);
    assign w_range_ok = (o_dir_x <= 18'sd65536) && (o_dir_x >= -18'sd65536)
                     && (o_dir_y <= 18'sd65536) && (o_dir_y >= -18'sd65536)
                     && (o_dir_z <= 18'sd65536) && (o_dir_z >= -18'sd65536);

    // Every accepted pixel produces its result after the fixed pipeline depth.
    `RPD_ASSERT_DELAY(a_fixed_latency, i_clk, i_rst_n, w_accept, LATENCY, o_strobe)
    // A zero-length vector reports all-zero components.
    `RPD_ASSERT_IMPL(a_zero_dirs, i_clk, i_rst_n, o_strobe && o_zero_length, w_zero_ok)
    // Components never exceed unit magnitude.
    `RPD_ASSERT_IMPL(a_unit_range, i_clk, i_rst_n, o_strobe, w_range_ok)

endmodule

// ----- dv/tb.sv -----
// tb.sv
// Self-checking testbench for pinhole_ray_direction_core: predicts each unit ray direction
// and compares it with the DUT output. Depends on rpd_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD        = rpd_pkg::COORD_BITS_DEF;
    localparam int COMP         = rpd_pkg::COMP_BITS_DEF;
    localparam int VEC          = 3 * COMP;
    localparam int OUT_BITS     = rpd_pkg::OUT_BITS;
    localparam int PITCH_BITS   = rpd_pkg::PITCH_BITS;
    localparam int NORM_BITS    = rpd_pkg::NORM_BITS;
    localparam int CFG_IDX_BITS = rpd_pkg::CFG_IDX_BITS;

    localparam logic [COORD-1:0] COORD_MAX = '1;
    localparam logic [COMP-1:0]  COMP_ONE  = COMP'(65536);   // 1.0 in Q3.16
    localparam logic [COMP-1:0]  COMP_MONE = -COMP'(65536);  // -1.0 in Q3.16
    localparam logic [COMP-1:0]  COMP_MIN  = {1'b1, {(COMP-1){1'b0}}};
    localparam logic [COMP-1:0]  COMP_MAX  = {1'b0, {(COMP-1){1'b1}}};

    // Random part: one camera setup per phase, the last phase runs with no idling.
    localparam int RAND_PHASES  = 11;
    localparam int PHASE_PIXELS = 130;
    localparam int RUN_LIMIT    = 400_000;

    typedef struct packed {
        logic [COORD-1:0] x;
        logic [COORD-1:0] y;
    } t_pixel;

    typedef struct packed {
        logic                zero;
        logic [OUT_BITS-1:0] dz;
        logic [OUT_BITS-1:0] dy;
        logic [OUT_BITS-1:0] dx;
    } t_ray;

    // DUT connections; every input starts at a known value.
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [COORD-1:0]           i_pixel_x = '0;
    logic [COORD-1:0]           i_pixel_y = '0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]    i_cfg_idx = '0;
    logic [VEC-1:0]             i_cfg_data = '0;
    logic                       o_strobe;
    logic signed [OUT_BITS-1:0] o_dir_x;
    logic signed [OUT_BITS-1:0] o_dir_y;
    logic signed [OUT_BITS-1:0] o_dir_z;
    logic                       o_zero_length;

    // Camera registers as the DUT holds them after each write.
    logic [VEC-1:0]        cam_start = '0;
    logic [VEC-1:0]        cam_right = '0;
    logic [VEC-1:0]        cam_up    = '0;
    logic [PITCH_BITS-1:0] cam_pix_w = '0;
    logic [PITCH_BITS-1:0] cam_pix_h = '0;

    t_pixel pixel_backlog[$];   // pixels waiting to be driven
    t_ray   pending_rays[$];    // predicted rays of accepted pixels, oldest first

    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          idle_odds = 3;  // one chance in idle_odds of an idle burst; 0 turns it off
    int          idle_left = 0;

    pinhole_ray_direction_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_dir_x       (o_dir_x),
        .o_dir_y       (o_dir_y),
        .o_dir_z       (o_dir_z),
        .o_zero_length (o_zero_length)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Signed Q3.16 component k of a packed vector (x lowest).
    function automatic longint axis(input logic [VEC-1:0] vec, input int k);
        return longint'($signed(vec[k*COMP +: COMP]));
    endfunction

    // Unit direction of the ray through one pixel under the current camera registers.
    function automatic t_ray unit_direction(input t_pixel px);
        longint              reach_x, reach_y, v;
        logic [63:0]         mag [3];
        logic [2:0]          neg;
        logic [63:0]         peak, energy, root, trial, q;
        logic [OUT_BITS-1:0] dir [3];
        int                  span, i, b;
        t_ray                ray;
        // Exact sum with 40 fraction bits: the start vector is lifted by the pitch width.
        reach_x = longint'(px.x) * longint'(cam_pix_w);
        reach_y = longint'(px.y) * longint'(cam_pix_h);
        peak = '0;
        for (i = 0; i < 3; i++) begin
            v = (axis(cam_start, i) <<< PITCH_BITS) + reach_x * axis(cam_right, i)
                + reach_y * axis(cam_up, i);
            neg[i] = (v < 0);
            mag[i] = neg[i] ? 64'(-v) : 64'(v);
            if (mag[i] > peak) peak = mag[i];
        end
        ray = '0;
        if (peak == 0) begin
            ray.zero = 1'b1;
        end else begin
            // Align so the largest magnitude has exactly NORM_BITS significant bits.
            span = $clog2(peak + 64'd1);
            energy = '0;
            for (i = 0; i < 3; i++) begin
                if (span > NORM_BITS) mag[i] = mag[i] >> (span - NORM_BITS);
                else mag[i] = mag[i] << (NORM_BITS - span);
                energy += mag[i] * mag[i];
            end
            // Floor square root, one bit at a time from the top.
            root = '0;
            for (b = NORM_BITS; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= energy) root = trial;
            end
            for (i = 0; i < 3; i++) begin
                q = (mag[i] * 64'd65536 + (root >> 1)) / root;
                if (q > 64'(rpd_pkg::UNIT_Q)) q = 64'(rpd_pkg::UNIT_Q);
                dir[i] = neg[i] ? OUT_BITS'(-q) : OUT_BITS'(q);
            end
            ray.dx = dir[0];
            ray.dy = dir[1];
            ray.dz = dir[2];
        end
        return ray;
    endfunction

    // Driver: take a transaction at start && !busy, hold it while busy, otherwise
    // idle in bursts or advance to the next queued pixel.
    always @(posedge i_clk) begin : drive_pixels
        t_pixel next_px;
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy) begin
                next_px.x = i_pixel_x;
                next_px.y = i_pixel_y;
                pending_rays.push_back(unit_direction(next_px));
            end
            if (start && busy) begin
                // hold the offered pixel until the core takes it
            end else if (idle_left != 0) begin
                start <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                // start an idle burst; idle_left holds the rest of it
                start <= 1'b0;
                idle_left <= $urandom_range(0, 16);
            end else if (pixel_backlog.size() != 0) begin
                next_px = pixel_backlog.pop_front();
                start <= 1'b1;
                i_pixel_x <= next_px.x;
                i_pixel_y <= next_px.y;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [OUT_BITS-1:0] want,
                               input logic [OUT_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, $signed(want), $signed(got));
            mismatch_count++;
        end
    endtask

    // Monitor: every strobe retires the oldest predicted ray.
    always @(posedge i_clk) begin : check_rays
        t_ray want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_rays.size() == 0) begin
                $display("%0t: unexpected ray: expected none, actual %0d %0d %0d zero=%0b",
                         $time, o_dir_x, o_dir_y, o_dir_z, o_zero_length);
                mismatch_count++;
            end else begin
                want = pending_rays.pop_front();
                check_field("dir_x", want.dx, o_dir_x);
                check_field("dir_y", want.dy, o_dir_y);
                check_field("dir_z", want.dz, o_dir_z);
                check_field("zero_length", OUT_BITS'(want.zero), OUT_BITS'(o_zero_length));
            end
        end
    end

    // Write one register and update the shadow copy; drop the enable on the next edge.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [VEC-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            rpd_pkg::CFG_START_VEC: cam_start = data;
            rpd_pkg::CFG_RIGHT_VEC: cam_right = data;
            rpd_pkg::CFG_UP_VEC:    cam_up    = data;
            rpd_pkg::CFG_PIX_W:     cam_pix_w = data[PITCH_BITS-1:0];
            rpd_pkg::CFG_PIX_H:     cam_pix_h = data[PITCH_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_camera(input logic [VEC-1:0] s, input logic [VEC-1:0] r,
                              input logic [VEC-1:0] u, input logic [VEC-1:0] pw,
                              input logic [VEC-1:0] ph);
        write_reg(rpd_pkg::CFG_START_VEC, s);
        write_reg(rpd_pkg::CFG_RIGHT_VEC, r);
        write_reg(rpd_pkg::CFG_UP_VEC, u);
        write_reg(rpd_pkg::CFG_PIX_W, pw);
        write_reg(rpd_pkg::CFG_PIX_H, ph);
    endtask

    function automatic logic [VEC-1:0] pack_vec(input logic [COMP-1:0] cx,
                                                input logic [COMP-1:0] cy,
                                                input logic [COMP-1:0] cz);
        return {cz, cy, cx};
    endfunction

    task automatic queue_pixel(input logic [COORD-1:0] x, input logic [COORD-1:0] y);
        t_pixel px;
        px.x = x;
        px.y = y;
        pixel_backlog.push_back(px);
    endtask

    // Idle: no pixel queued or offered and no ray outstanding. Sample away from the
    // driving edge so queue and start are seen consistently.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_backlog.size() != 0 || start || pending_rays.size() != 0);
    endtask

    function automatic logic [COMP-1:0] random_comp();
        case ($urandom_range(0, 5))
            0: return COMP_MIN;
            1: return COMP_MAX;
            2: return '0;
            3: return COMP'($urandom_range(0, 16)) - COMP'(8);
            default: return COMP'($urandom());
        endcase
    endfunction

    // Pitch with random junk above bit 23, which the core must ignore.
    function automatic logic [VEC-1:0] random_pitch_word();
        logic [VEC-1:0] word;
        word = VEC'({$urandom(), $urandom()});
        case ($urandom_range(0, 5))
            0: word[PITCH_BITS-1:0] = '1;
            1: word[PITCH_BITS-1:0] = '0;
            2: word[PITCH_BITS-1:0] = PITCH_BITS'($urandom_range(1, 4096));
            default: ;
        endcase
        return word;
    endfunction

    function automatic logic [COORD-1:0] random_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return COORD_MAX;
            default: return COORD'($urandom());
        endcase
    endfunction

    initial begin : stimulus
        int p, n, k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at reset are all zero: every ray is the zero vector.
        queue_pixel('0, '0);
        queue_pixel(COORD_MAX, COORD_MAX);
        queue_pixel(COORD_MAX, '0);
        queue_pixel('0, COORD_MAX);
        wait_drained();

        // Axis-aligned camera looking down +z; pixel (0,0) lands exactly on the
        // clamp at 1.0, up points down to bring negative components in.
        set_camera(pack_vec('0, '0, COMP_ONE), pack_vec(COMP_ONE, '0, '0),
                   pack_vec('0, COMP_MONE, '0), VEC'(4096), VEC'(4096));
        queue_pixel('0, '0);
        queue_pixel(COORD_MAX, COORD_MAX);
        queue_pixel(COORD'(2048), '0);
        queue_pixel('0, COORD'(2048));
        wait_drained();

        // Extremes: most negative and most positive components, full pitches.
        set_camera(pack_vec(COMP_MIN, COMP_MIN, COMP_MIN), pack_vec(COMP_MAX, COMP_MAX, COMP_MAX),
                   pack_vec(COMP_MIN, COMP_MIN, COMP_MIN), VEC'(24'hFFFFFF), VEC'(24'hFFFFFF));
        queue_pixel('0, '0);
        queue_pixel(COORD_MAX, COORD_MAX);
        queue_pixel(COORD_MAX, '0);
        queue_pixel('0, COORD_MAX);
        queue_pixel(COORD'(1), COORD'(1));
        wait_drained();

        // Cancellation: start -1.0 on x, right +1.0, half pitch, so column 2 sums to
        // exactly zero; up is zero so the row does not matter.
        set_camera(pack_vec(COMP_MONE, '0, '0), pack_vec(COMP_ONE, '0, '0), '0,
                   VEC'(24'h800000), VEC'(24'hFFFFFF));
        queue_pixel(COORD'(2), '0);
        queue_pixel(COORD'(2), COORD_MAX);
        queue_pixel('0, '0);
        queue_pixel(COORD_MAX, COORD'(7));
        queue_pixel(COORD'(1), '0);
        wait_drained();

        for (p = 0; p < RAND_PHASES; p++) begin
            // Indexes past the register list must leave the camera untouched.
            for (k = int'(rpd_pkg::CFG_PIX_H) + 1; k < (1 << CFG_IDX_BITS); k++)
                write_reg(CFG_IDX_BITS'(k), VEC'({$urandom(), $urandom()}));
            set_camera(pack_vec(random_comp(), random_comp(), random_comp()),
                       pack_vec(random_comp(), random_comp(), random_comp()),
                       pack_vec(random_comp(), random_comp(), random_comp()),
                       random_pitch_word(), random_pitch_word());
            if (p == RAND_PHASES - 1) idle_odds = 0;
            else if (p % 3 == 0) idle_odds = 0;
            else if (p % 3 == 1) idle_odds = 3;
            else idle_odds = 12;
            for (n = 0; n < PHASE_PIXELS; n++)
                queue_pixel(random_coord(), random_coord());
            wait_drained();
        end

        // Let the pipeline run empty to catch stray strobes.
        repeat (rpd_pkg::LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_rays.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
